// ----- hdl/ring_queue_with_erase_top_macros.svh -----
`ifndef RING_QUEUE_WITH_ERASE_TOP_MACROS_SVH
`define RING_QUEUE_WITH_ERASE_TOP_MACROS_SVH

// Same-cycle check: when cond holds, expect holds on the same edge.
`define RQE_ASSERT_NOW(label, cond, expect_c, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |-> (expect_c)) else $error(msg);

// Next-cycle check: when cond holds, expect is checked on the next edge.
`define RQE_ASSERT_NEXT(label, cond, expect_c, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |=> (expect_c)) else $error(msg);

`endif

// ----- hdl/rqe_pkg.sv -----
package rqe_pkg;

   // Default sizing
   localparam int DEPTH_DEFAULT        = 64;
   localparam int HANDLE_WIDTH_DEFAULT = 32;

   // Fixed field widths
   localparam int CMD_W = 3;
   localparam int OFS_W = 6;
   localparam int CNT_W = 7;
   localparam int STS_W = 3;

   // Capacity register reset value
   localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ERASE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

   // Status codes
   localparam logic [STS_W-1:0] STS_OK    = 3'd0;
   localparam logic [STS_W-1:0] STS_EMPTY = 3'd1;
   localparam logic [STS_W-1:0] STS_FULL  = 3'd2;
   localparam logic [STS_W-1:0] STS_RANGE = 3'd3;
   localparam logic [STS_W-1:0] STS_NULL  = 3'd4;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_ERASE,
      S_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_req;   // capture request word, issue first read
      logic exec_go;    // execute captured command
      logic shift_go;   // move one entry forward during erase
      logic finish_go;  // close out erase, publish result
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic erase_ok;   // captured erase is valid
      logic erase_tail; // erase target is the last entry, nothing to move
      logic shift_last; // current shift is the final one
   } dp_status_type;

endpackage

// ----- hdl/rqe_ctrl.sv -----
`include "ring_queue_with_erase_top_macros.svh"

module rqe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rqe_pkg::dp_status_type status_i,
   output rqe_pkg::ctl_cmd_type  cmd
);
   import rqe_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      rsp_load;

   // Output register can take a word this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               if (status_i.erase_ok) begin
                  state_in = status_i.erase_tail ? S_DONE : S_ERASE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ERASE: begin
            if (status_i.shift_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         S_EXEC: begin
            cmd.exec_go = out_free;
         end
         S_ERASE: begin
            cmd.shift_go = 1'b1;
         end
         S_DONE: begin
            cmd.finish_go = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Result word handoff
   assign rsp_load = (cmd.exec_go && !status_i.erase_ok) || cmd.finish_go;

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RQE_ASSERT_NEXT(a_accept_to_exec, req_valid && !req_stall, state_ff == S_EXEC, "accept did not start execution")
   `RQE_ASSERT_NOW(a_no_overwrite, rsp_valid_ff && rsp_stall, !rsp_load, "stalled result word overwritten")
   `RQE_ASSERT_NOW(a_erase_entry, state_ff == S_ERASE, $past(state_ff) == S_EXEC || $past(state_ff) == S_ERASE, "erase shift entered from wrong state")

endmodule

// ----- hdl/rqe_datapath.sv -----
`include "ring_queue_with_erase_top_macros.svh"

module rqe_datapath #(
   parameter int DEPTH        = rqe_pkg::DEPTH_DEFAULT,
   parameter int HANDLE_WIDTH = rqe_pkg::HANDLE_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rqe_pkg::ctl_cmd_type      cmd,
   output rqe_pkg::dp_status_type    status_o,
   input  logic                      csr_write,
   input  logic [rqe_pkg::CNT_W-1:0] csr_capacity_in_use,
   input  logic [rqe_pkg::CMD_W-1:0] req_command,
   input  logic [HANDLE_WIDTH-1:0]   req_handle,
   input  logic [rqe_pkg::OFS_W-1:0] req_offset,
   output logic [HANDLE_WIDTH-1:0]   rsp_data_out,
   output logic [rqe_pkg::CNT_W-1:0] rsp_count_after,
   output logic [rqe_pkg::STS_W-1:0] rsp_status
);
   import rqe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // Room for head plus a position up to two past the count
   localparam int SUM_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 2;
   localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

   // Zero acts as one, anything above the ring size acts as the ring size
   function automatic logic [SUM_W-1:0] clamp_cap(input logic [CNT_W-1:0] raw);
      logic [SUM_W-1:0] c;
      c = SUM_W'(raw);
      if (c == '0) c = SUM_W'(1);
      if (c > DEPTH_S) c = DEPTH_S;
      return c;
   endfunction

   // Physical slot of a position counted from the head; head + position < 2 * cap
   function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                input logic [SUM_W-1:0] pos,
                                                input logic [SUM_W-1:0] cap);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + pos;
      if (sum >= cap) sum = sum - cap;
      return sum[PTR_W-1:0];
   endfunction

   // Ring memory
   logic [HANDLE_WIDTH-1:0] ring_mem [DEPTH];

   logic [SUM_W-1:0]        cap_ff, cap_in;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        cursor_ff, cursor_in;
   logic [CMD_W-1:0]        cmd_ff;
   logic [HANDLE_WIDTH-1:0] handle_ff;
   logic [HANDLE_WIDTH-1:0] rd_data_ff;
   logic [HANDLE_WIDTH-1:0] rsp_data_ff;
   logic [CNT_W-1:0]        rsp_count_ff;
   logic [STS_W-1:0]        rsp_status_ff;

   logic [SUM_W-1:0]        count_s, cursor_s, cursor_p2;
   logic [SUM_W-1:0]        req_pos, rd_pos, wr_pos;
   logic [PTR_W-1:0]        rd_slot, wr_slot, head_next;
   logic                    is_empty, in_range, push_ok;
   logic                    rd_en, wr_en, rsp_load;
   logic [HANDLE_WIDTH-1:0] wr_data;
   logic [HANDLE_WIDTH-1:0] res_data;
   logic [STS_W-1:0]        res_status;

   // Decode of the captured word
   assign count_s   = SUM_W'(count_ff);
   assign cursor_s  = SUM_W'(cursor_ff);
   assign cursor_p2 = cursor_s + SUM_W'(2);
   assign is_empty  = (count_ff == '0);
   assign in_range  = (cursor_s < count_s);
   assign push_ok   = (cmd_ff == CMD_PUSH) && (handle_ff != '0) && (count_s < cap_ff);

   assign status_o.erase_ok   = (cmd_ff == CMD_ERASE) && !is_empty && in_range;
   assign status_o.erase_tail = (cursor_s + SUM_W'(1)) == count_s;
   assign status_o.shift_last = (cursor_p2 == count_s);

   // Read port: front or offset entry at accept, entry behind cursor during erase
   assign req_pos = (req_command == CMD_POP) ? '0 : SUM_W'(req_offset);
   assign rd_pos  = cmd.load_req ? req_pos :
                    (cmd.shift_go ? cursor_p2 : cursor_s + SUM_W'(1));
   assign rd_slot = slot_of(head_ff, rd_pos, cap_ff);
   assign rd_en   = cmd.load_req || (cmd.exec_go && status_o.erase_ok) || cmd.shift_go;

   // Write port: push at the tail, or move an entry forward
   assign wr_pos  = cmd.shift_go ? cursor_s : count_s;
   assign wr_slot = slot_of(head_ff, wr_pos, cap_ff);
   assign wr_en   = cmd.shift_go || (cmd.exec_go && push_ok);
   assign wr_data = cmd.shift_go ? rd_data_ff : handle_ff;

   assign head_next = slot_of(head_ff, SUM_W'(1), cap_ff);

   // Command execution and result word
   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      res_data   = '0;
      res_status = STS_OK;
      if (cmd.exec_go) begin
         case (cmd_ff)
            CMD_PUSH: begin
               if (handle_ff == '0) begin
                  res_status = STS_NULL;
               end else if (!push_ok) begin
                  res_status = STS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_POP: begin
               if (is_empty) begin
                  res_status = STS_EMPTY;
               end else begin
                  res_data = rd_data_ff;
                  count_in = count_ff - 1'b1;
                  head_in  = (count_ff == CNT_W'(1)) ? '0 : head_next;
               end
            end
            CMD_READ: begin
               if (is_empty) begin
                  res_status = STS_EMPTY;
               end else if (!in_range) begin
                  res_status = STS_RANGE;
               end else begin
                  res_data = rd_data_ff;
               end
            end
            CMD_ERASE: begin
               if (is_empty) begin
                  res_status = STS_EMPTY;
               end else if (!in_range) begin
                  res_status = STS_RANGE;
               end
            end
            CMD_CLEAR: begin
               head_in  = '0;
               count_in = '0;
            end
            default: begin
               res_status = STS_OK;
            end
         endcase
      end else if (cmd.finish_go) begin
         // erase completes: one entry fewer
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) head_in = '0;
      end
   end

   assign rsp_load = (cmd.exec_go && !status_o.erase_ok) || cmd.finish_go;

   // Cursor follows the erase position
   always_comb begin
      if (cmd.load_req) begin
         cursor_in = CNT_W'(req_offset);
      end else if (cmd.shift_go) begin
         cursor_in = cursor_ff + 1'b1;
      end else begin
         cursor_in = cursor_ff;
      end
   end

   assign cap_in = csr_write ? clamp_cap(csr_capacity_in_use) : cap_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= clamp_cap(CAP_RESET);
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         cap_ff   <= cap_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Captured request and result payload
   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      if (cmd.load_req) begin
         cmd_ff    <= req_command;
         handle_ff <= req_handle;
      end
      if (rsp_load) begin
         rsp_data_ff   <= res_data;
         rsp_count_ff  <= count_in;
         rsp_status_ff <= res_status;
      end
   end

   // Ring memory ports
   always_ff @(posedge clock) begin
      if (wr_en) ring_mem[wr_slot] <= wr_data;
      if (rd_en) rd_data_ff <= ring_mem[rd_slot];
   end

   assign rsp_data_out    = rsp_data_ff;
   assign rsp_count_after = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   `RQE_ASSERT_NOW(a_head_home, count_ff == '0, head_ff == '0, "head not at slot zero on empty queue")
   `RQE_ASSERT_NOW(a_shift_span, cmd.shift_go, cursor_p2 <= count_s, "erase shift beyond queued entries")
   `RQE_ASSERT_NEXT(a_push_grows, cmd.exec_go && push_ok, count_ff == $past(count_ff) + 1'b1, "accepted push did not grow count")

endmodule

// ----- hdl/ring_queue_with_erase_top.sv -----
// Bounded ring queue of buffer handles with push, pop front, read at offset,
// erase at offset and clear; every request word gives exactly one response
// word carrying the popped or read handle, the entry count afterwards and a
// status code. For every command the memory read is issued at accept and the
// command executes once the output register is free. An erase then moves the
// entries behind the erased one forward one per cycle through the single read
// and write port of the ring memory, and its result is published once the
// output register is free. A new request is taken only after the previous
// one is complete; a finished response may wait in its output register while
// the next request is accepted. The user must write the capacity register
// only while the queue is idle; the block itself does not enforce this.
// 0 acts as 1 and values above DEPTH act as DEPTH.
`include "ring_queue_with_erase_top_macros.svh"

module ring_queue_with_erase_top #(
   parameter int DEPTH        = rqe_pkg::DEPTH_DEFAULT,
   parameter int HANDLE_WIDTH = rqe_pkg::HANDLE_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [rqe_pkg::CNT_W-1:0] csr_capacity_in_use,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [rqe_pkg::CMD_W-1:0] req_command,
   input  logic [HANDLE_WIDTH-1:0]   req_handle,
   input  logic [rqe_pkg::OFS_W-1:0] req_offset,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [HANDLE_WIDTH-1:0]   rsp_data_out,
   output logic [rqe_pkg::CNT_W-1:0] rsp_count_after,
   output logic [rqe_pkg::STS_W-1:0] rsp_status
);
   import rqe_pkg::*;

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   // Sequencer
   rqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status_i  (dp_status),
      .cmd       (ctl_cmd)
   );

   // Ring memory, pointers and result register
   rqe_datapath #(
      .DEPTH        (DEPTH),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (ctl_cmd),
      .status_o            (dp_status),
      .csr_write           (csr_write),
      .csr_capacity_in_use (csr_capacity_in_use),
      .req_command         (req_command),
      .req_handle          (req_handle),
      .req_offset          (req_offset),
      .rsp_data_out        (rsp_data_out),
      .rsp_count_after     (rsp_count_after),
      .rsp_status          (rsp_status)
   );

   `RQE_ASSERT_NEXT(a_stall_after_accept, req_valid && !req_stall, req_stall, "request taken while busy")
   `RQE_ASSERT_NOW(a_rsp_hold_data, rsp_valid && $past(rsp_valid && rsp_stall), $stable(rsp_data_out), "stalled response data changed")
   `RQE_ASSERT_NOW(a_rsp_hold_status, rsp_valid && $past(rsp_valid && rsp_stall), $stable(rsp_status) && $stable(rsp_count_after), "stalled response status changed")

endmodule

// ----- tb/rqe_reply_checker.sv -----
`timescale 1ns / 1ps

// Watches the request, response and capacity ports of the ring queue, predicts
// every response word and compares it field by field, oldest first.
module rqe_reply_checker #(
   parameter int DEPTH        = rqe_pkg::DEPTH_DEFAULT,
   parameter int HANDLE_WIDTH = rqe_pkg::HANDLE_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [rqe_pkg::CNT_W-1:0] csr_capacity_in_use,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [rqe_pkg::CMD_W-1:0] req_command,
   input  logic [HANDLE_WIDTH-1:0]   req_handle,
   input  logic [rqe_pkg::OFS_W-1:0] req_offset,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [HANDLE_WIDTH-1:0]   rsp_data_out,
   input  logic [rqe_pkg::CNT_W-1:0] rsp_count_after,
   input  logic [rqe_pkg::STS_W-1:0] rsp_status,
   output int unsigned               mismatch_count,
   output int unsigned               replies_owed
);
   import rqe_pkg::*;

   typedef struct packed {
      logic [HANDLE_WIDTH-1:0] data;
      logic [CNT_W-1:0]        count;
      logic [STS_W-1:0]        status;
   } queue_reply_type;

   // Shadow of the queue
   logic [HANDLE_WIDTH-1:0] ring_mem [DEPTH];
   logic [OFS_W-1:0]        front_slot;
   int unsigned             queued;
   logic [CNT_W-1:0]        slot_limit;

   // Responses still owed by the block, oldest first
   queue_reply_type awaited_replies [$];

   function automatic int unsigned live_slots();
      if (slot_limit == '0) return 1;
      if (slot_limit > DEPTH) return DEPTH;
      return int'(slot_limit);
   endfunction

   function automatic int unsigned ring_pos(input int unsigned k);
      return (front_slot + k) % live_slots();
   endfunction

   // Apply one request word to the shadow queue, return the response it owes
   function automatic queue_reply_type execute_queue_op(input logic [CMD_W-1:0] cmd,
                                                        input logic [HANDLE_WIDTH-1:0] h,
                                                        input logic [OFS_W-1:0] ofs);
      queue_reply_type r;
      int unsigned s;
      int unsigned i;
      r.data   = '0;
      r.status = STS_OK;
      case (cmd)
         CMD_PUSH: begin
            // null check comes ahead of the full check
            if (h == '0) r.status = STS_NULL;
            else if (queued >= live_slots()) r.status = STS_FULL;
            else begin
               ring_mem[ring_pos(queued)] = h;
               queued++;
            end
         end
         CMD_POP: begin
            if (queued == 0) r.status = STS_EMPTY;
            else begin
               s = ring_pos(0);
               r.data = ring_mem[s];
               ring_mem[s] = '0;
               front_slot = OFS_W'(ring_pos(1));
               queued--;
               if (queued == 0) front_slot = '0;
            end
         end
         CMD_READ, CMD_ERASE: begin
            if (queued == 0) r.status = STS_EMPTY;
            else if (ofs >= queued) r.status = STS_RANGE;
            else if (cmd == CMD_READ) r.data = ring_mem[ring_pos(ofs)];
            else begin
               // later entries close the gap one place at a time
               for (i = ofs; i + 1 < queued; i++)
                  ring_mem[ring_pos(i)] = ring_mem[ring_pos(i + 1)];
               ring_mem[ring_pos(queued - 1)] = '0;
               queued--;
               if (queued == 0) front_slot = '0;
            end
         end
         CMD_CLEAR: begin
            for (i = 0; i < DEPTH; i++) ring_mem[i] = '0;
            front_slot = '0;
            queued = 0;
         end
         default: ;
      endcase
      r.count = CNT_W'(queued);
      return r;
   endfunction

   // One line per bad field, and every mismatch counts
   task automatic report_mismatch(input string what, input logic [HANDLE_WIDTH-1:0] want_v,
                                  input logic [HANDLE_WIDTH-1:0] got_v);
      mismatch_count++;
      $display("%0t ns: response %s mismatch, expected %h, got %h",
               $time, what, want_v, got_v);
   endtask

   always @(posedge clock) begin : watch_channels
      queue_reply_type got;
      queue_reply_type want;
      int unsigned     i;
      if (reset) begin
         for (i = 0; i < DEPTH; i++) ring_mem[i] = '0;
         front_slot = '0;
         queued = 0;
         slot_limit = CAP_RESET;
         awaited_replies.delete();
         mismatch_count = 0;
      end else begin
         // response word taken by the receiver
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_data_out, rsp_count_after, rsp_status};
            if (awaited_replies.size() == 0) begin
               report_mismatch("word with none pending", '0, got.data);
            end else begin
               want = awaited_replies[0];
               awaited_replies.delete(0);
               if (got.data !== want.data)
                  report_mismatch("data_out", want.data, got.data);
               if (got.count !== want.count)
                  report_mismatch("count_after", HANDLE_WIDTH'(want.count),
                                  HANDLE_WIDTH'(got.count));
               if (got.status !== want.status)
                  report_mismatch("status", HANDLE_WIDTH'(want.status),
                                  HANDLE_WIDTH'(got.status));
            end
         end
         if (csr_write) slot_limit = csr_capacity_in_use;
         // request word taken by the block
         if (req_valid && !req_stall)
            awaited_replies.insert(awaited_replies.size(),
                                   execute_queue_op(req_command, req_handle, req_offset));
      end
      replies_owed <= awaited_replies.size();
   end

endmodule

// ----- tb/tb_ring_queue_with_erase_top.sv -----
`timescale 1ns / 1ps

module tb_ring_queue_with_erase_top;
   import rqe_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   localparam int HW    = HANDLE_WIDTH_DEFAULT;
   localparam int RUN_LIMIT  = 1_000_000;
   localparam int HOLD_SPAN  = 60;
   localparam int PHASES     = 9;
   localparam int MIX_BUDGET = 32;

   // Command codes the block leaves unused
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   typedef enum int {FILL_BIAS, DRAIN_BIAS, MIXED_BIAS} mix_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             csr_write = 1'b0;
   logic [CNT_W-1:0] csr_capacity_in_use = '0;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [CMD_W-1:0] req_command = '0;
   logic [HW-1:0]    req_handle = '0;
   logic [OFS_W-1:0] req_offset = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b1;
   logic [HW-1:0]    rsp_data_out;
   logic [CNT_W-1:0] rsp_count_after;
   logic [STS_W-1:0] rsp_status;

   int unsigned mismatch_count;
   int unsigned replies_owed;

   int send_gap_pct = 25;
   int rsp_hold_pct = 85;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int words_sent = 0;
   int fill_level = 0;
   int fill_limit = DEPTH;

   ring_queue_with_erase_top #(
      .DEPTH        (DEPTH),
      .HANDLE_WIDTH (HW)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_capacity_in_use (csr_capacity_in_use),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_handle          (req_handle),
      .req_offset          (req_offset),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data_out        (rsp_data_out),
      .rsp_count_after     (rsp_count_after),
      .rsp_status          (rsp_status)
   );

   rqe_reply_checker #(
      .DEPTH        (DEPTH),
      .HANDLE_WIDTH (HW)
   ) u_reply_check (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_capacity_in_use (csr_capacity_in_use),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_handle          (req_handle),
      .req_offset          (req_offset),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data_out        (rsp_data_out),
      .rsp_count_after     (rsp_count_after),
      .rsp_status          (rsp_status),
      .mismatch_count      (mismatch_count),
      .replies_owed        (replies_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("Timed out after %0d cycles with %0d words owed", cycle_count, replies_owed);
         $display("[ring_queue_with_erase_top] ERROR");
         $finish;
      end
   end

   // Receiver: random stall, or a long hold when the stimulus asks for one
   always @(posedge clock) begin
      if (hold_asked != hold_served) begin
         hold_served = hold_asked;
         hold_left = HOLD_SPAN;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
      end
   end

   function automatic int usable_slots(input logic [CNT_W-1:0] v);
      if (v == '0) return 1;
      if (v > DEPTH) return DEPTH;
      return int'(v);
   endfunction

   function automatic logic [HW-1:0] any_handle();
      logic [HW-1:0] h;
      h = HW'($urandom);
      if (h == '0) h = HW'(1);
      return h;
   endfunction

   // Offer one request word and hold it until the block takes it
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [HW-1:0] h,
                            input logic [OFS_W-1:0] ofs);
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_handle  <= h;
      req_offset  <= ofs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      // rough fill level, only used to aim offsets
      case (cmd)
         CMD_PUSH:  if (h != '0 && fill_level < fill_limit) fill_level++;
         CMD_POP:   if (fill_level > 0) fill_level--;
         CMD_ERASE: if (ofs < fill_level) fill_level--;
         CMD_CLEAR: fill_level = 0;
         default: ;
      endcase
   endtask

   // Empty the queue, let every response drain, then write the capacity
   task automatic set_capacity(input logic [CNT_W-1:0] v);
      send_word(CMD_CLEAR, HW'($urandom), OFS_W'($urandom));
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_owed != 0) @(posedge clock);
      csr_write           <= 1'b1;
      csr_capacity_in_use <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      fill_limit = usable_slots(v);
   endtask

   // Push to the brim, then a null push and a push on the full queue
   task automatic fill_to_brim();
      repeat (fill_limit) send_word(CMD_PUSH, any_handle(), OFS_W'($urandom));
      send_word(CMD_PUSH, '0, OFS_W'($urandom));
      send_word(CMD_PUSH, any_handle(), OFS_W'($urandom));
   endtask

   task automatic random_word(input mix_type mode);
      int r;
      int c_push;
      int c_pop;
      int c_read;
      int c_erase;
      logic [CMD_W-1:0] cmd;
      logic [HW-1:0]    h;
      logic [OFS_W-1:0] ofs;
      r = $urandom_range(99);
      h = any_handle();
      if (fill_level > 0 && $urandom_range(99) < 85)
         ofs = OFS_W'($urandom_range(fill_level - 1, 0));
      else ofs = OFS_W'($urandom_range(DEPTH - 1, 0));
      case (mode)
         FILL_BIAS:  begin c_push = 60; c_pop = 70; c_read = 82; c_erase = 92; end
         DRAIN_BIAS: begin c_push = 15; c_pop = 55; c_read = 70; c_erase = 90; end
         default:    begin c_push = 35; c_pop = 58; c_read = 74; c_erase = 90; end
      endcase
      if (r < c_push) cmd = CMD_PUSH;
      else if (r < c_pop) cmd = CMD_POP;
      else if (r < c_read) cmd = CMD_READ;
      else if (r < c_erase) cmd = CMD_ERASE;
      else if (r < c_erase + 2) cmd = CMD_CLEAR;
      else if (r < c_erase + 5) cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
      else begin
         cmd = CMD_PUSH;
         h = '0;
      end
      send_word(cmd, h, ofs);
   endtask

   initial begin : stimulus
      logic [CNT_W-1:0] caps [PHASES];
      mix_type mode;
      int      n;
      caps = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127, 7'd5, 7'd100, 7'd3, 7'd64};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset capacity
      send_word(CMD_POP, '0, '0);
      send_word(CMD_READ, '0, '0);
      send_word(CMD_ERASE, '0, '0);
      send_word(CMD_PUSH, '0, '0);
      send_word(CMD_PUSH, '1, '1);
      send_word(CMD_PUSH, 32'h0000_0001, '0);
      send_word(CMD_PUSH, 32'h8000_0000, '0);
      send_word(CMD_PUSH, 32'h5555_AAAA, '0);
      send_word(CMD_READ, '0, 6'd0);
      send_word(CMD_READ, '0, 6'd3);
      send_word(CMD_READ, '0, 6'd4);
      send_word(CMD_READ, '0, '1);
      send_word(CMD_ERASE, '0, 6'd1);
      send_word(CMD_ERASE, '0, 6'd2);
      send_word(CMD_ERASE, '0, 6'd3);
      send_word(CMD_SPARE_LO, '1, '1);
      send_word(CMD_SPARE_LO + 3'd1, '1, '0);
      send_word(CMD_SPARE_HI, '0, '1);
      send_word(CMD_POP, '0, '0);
      send_word(CMD_POP, '0, '0);
      send_word(CMD_PUSH, 32'hA5A5_5A5A, '0);
      send_word(CMD_CLEAR, '1, '1);

      // Random phases, one capacity each; idle pattern changes every third
      for (int p = 0; p < PHASES; p++) begin
         case (p / 3)
            0:       begin send_gap_pct = 25; rsp_hold_pct = 85; end
            1:       begin send_gap_pct = 85; rsp_hold_pct = 25; end
            default: begin send_gap_pct = 0;  rsp_hold_pct = 0;  end
         endcase
         set_capacity(caps[p]);
         // long receiver hold while the sender keeps offering words
         if (p == 7) hold_asked++;
         fill_to_brim();
         mode = MIXED_BIAS;
         for (n = 0; n < MIX_BUDGET; n++) begin
            if (n % 16 == 0) mode = mix_type'($urandom_range(2));
            random_word(mode);
         end
      end

      // Drain
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_owed != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("Sent %0d request words over %0d capacity settings from 0 to 127,", words_sent,
               PHASES);
      $display("with full-queue fills, erase shifts, wraparound and three idle patterns.");
      if (mismatch_count == 0) begin
         $display("[ring_queue_with_erase_top] OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("[ring_queue_with_erase_top] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/rqe_pkg.sv
hdl/rqe_ctrl.sv
hdl/rqe_datapath.sv
hdl/ring_queue_with_erase_top.sv
tb/rqe_reply_checker.sv
tb/tb_ring_queue_with_erase_top.sv
